[sv/dtfc_pkg.sv]
// Package for the double-to-format converter: codes for target format and rounding mode.
// Used by double_to_format_convert_rm and the testbench. No dependencies.
`timescale 1ns / 1ps
package dtfc_pkg;

  typedef enum logic [1:0] {
    OP_SINGLE = 2'd0,
    OP_DOUBLE = 2'd1,
    OP_INT32  = 2'd2,
    OP_INT64  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RM_NEAREST = 3'd0,
    RM_ZERO    = 3'd1,
    RM_UP      = 3'd2,
    RM_DOWN    = 3'd3,
    RM_LEGACY  = 3'd4
  } rm_t;

  localparam logic [63:0] MAX_POS_64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MAX_POS_32 = 64'h0000_0000_7fff_ffff;

endpackage

[sv/double_to_format_convert_rm.sv]
// Converts an IEEE 754 double pattern to single, double, int32 or int64 with a rounding
// mode. The converter is a four-stage pipeline: decode and shift, round decision, increment,
// then range and special-case packing into an output register. One transaction enters per
// cycle while in_stall is low; an accepted transaction moves through the stage registers in
// order to the output register and is held there until taken. A stall at the output
// holds every stage at once (a global enable), so the input stall equals the output stall
// while the pipeline holds a valid item in its last stage.
// Rounding modes 5 to 7 act as legacy truncation. Depends on dtfc_pkg.
`timescale 1ns / 1ps
module double_to_format_convert_rm
  import dtfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [2:0]  rounding_mode,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_word
);

  // Pipeline advances unless the output register holds an untaken result.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- stage 1: decode and align ----------------
  logic        v1;
  logic [1:0]  op1;
  logic [2:0]  rm1;
  logic        s1;
  logic [10:0] e1;
  logic [63:0] mag1;     // integer part (int) or truncated fraction (float)
  logic [63:0] rem1;     // dropped bits
  logic [63:0] half1;    // weight of the half
  logic        big1;     // int: exponent far out of range
  logic        nan1;     // exponent all ones
  logic        mz1;      // fraction zero

  logic [2:0]  rm_in;
  logic        s_in;
  logic [10:0] e_in;
  logic [51:0] m_in;
  logic [52:0] sig_in;
  logic [63:0] mag_c, rem_c, half_c;
  logic        big_c;
  logic [5:0]  sh_c;

  always_comb begin
    rm_in  = (rounding_mode > RM_LEGACY) ? RM_LEGACY : rounding_mode;
    s_in   = value[63];
    e_in   = value[62:52];
    m_in   = value[51:0];
    sig_in = {1'b1, m_in};
    mag_c  = '0;
    rem_c  = '0;
    half_c = 64'd1;
    big_c  = 1'b0;
    sh_c   = '0;
    if (opcode == OP_SINGLE) begin
      mag_c  = {41'd0, m_in[51:29]};
      rem_c  = {35'd0, m_in[28:0]};
      half_c = 64'h1000_0000;
    end else if (opcode == OP_DOUBLE) begin
      mag_c  = {12'd0, m_in};
    end else if (e_in < 11'd1012) begin
      rem_c  = (e_in != 11'd0 || m_in != 52'd0) ? 64'd1 : 64'd0;
      half_c = 64'd2;
    end else if (e_in >= 11'd1087) begin
      big_c  = 1'b1;
    end else if (e_in >= 11'd1075) begin
      sh_c   = 6'(e_in - 11'd1075);
      mag_c  = {11'd0, sig_in} << sh_c;
    end else begin
      sh_c   = 6'(11'd1075 - e_in);
      mag_c  = {11'd0, sig_in} >> sh_c;
      rem_c  = {11'd0, sig_in} & ((64'd1 << sh_c) - 64'd1);
      half_c = 64'd1 << (sh_c - 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      op1  <= opcode;
      rm1  <= rm_in;
      s1   <= s_in;
      e1   <= e_in;
      mag1 <= mag_c;
      rem1 <= rem_c;
      half1 <= half_c;
      big1 <= big_c;
      nan1 <= (e_in == 11'h7ff);
      mz1  <= (m_in == 52'd0);
    end
  end

  // ---------------- stage 2: round decision ----------------
  logic        v2;
  logic [1:0]  op2;
  logic [2:0]  rm2;
  logic        s2, big2, nan2, mz2, up2;
  logic [10:0] e2;
  logic [63:0] mag2;
  logic        up_c;

  always_comb begin
    up_c = 1'b0;
    if (rem1 != 64'd0 && !big1) begin
      unique case (rm1)
        RM_NEAREST: up_c = (rem1 > half1) || (rem1 == half1 && mag1[0]);
        RM_UP:      up_c = !s1;
        RM_DOWN:    up_c = s1;
        default:    up_c = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      op2 <= op1; rm2 <= rm1; s2 <= s1; e2 <= e1;
      mag2 <= mag1; big2 <= big1; nan2 <= nan1; mz2 <= mz1; up2 <= up_c;
    end
  end

  // ---------------- stage 3: increment ----------------
  logic        v3;
  logic [1:0]  op3;
  logic [2:0]  rm3;
  logic        s3, big3, nan3, mz3;
  logic [10:0] e3;
  logic [64:0] mag3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      op3 <= op2; rm3 <= rm2; s3 <= s2; e3 <= e2;
      big3 <= big2; nan3 <= nan2; mz3 <= mz2;
      mag3 <= {1'b0, mag2} + {64'd0, up2};
    end
  end

  // ---------------- stage 4: range and pack ----------------
  logic        sgl3, w3, to_inf3, carry3;
  logic [12:0] ex3;      // rebiased exponent, signed range kept nonnegative by offset
  logic [12:0] maxexp3;
  logic [52:0] frac3;
  logic [63:0] lim3, maxpos3, neg3, res_c;
  logic [63:0] sbit3;

  always_comb begin
    sgl3    = (op3 == OP_SINGLE);
    w3      = (op3 == OP_INT32);
    maxexp3 = sgl3 ? 13'd255 : 13'd2047;
    sbit3   = sgl3 ? {32'd0, s3, 31'd0} : {s3, 63'd0};
    carry3  = sgl3 ? mag3[23] : mag3[52];
    frac3   = carry3 ? 53'd0 : mag3[52:0];
    // exponent rebias: e - 1023 + bias (+ carry), computed with offset 1023
    ex3     = {2'b0, e3} + {12'd0, carry3} - (sgl3 ? 13'd896 : 13'd0);
    if (sgl3 && ({2'b0, e3} + {12'd0, carry3}) < 13'd897) ex3 = 13'd0;
    if (ex3 > maxexp3) ex3 = maxexp3;
    unique case (rm3)
      RM_ZERO: to_inf3 = 1'b0;
      RM_UP:   to_inf3 = !s3;
      RM_DOWN: to_inf3 = s3;
      default: to_inf3 = 1'b1;
    endcase
    maxpos3 = w3 ? MAX_POS_32 : MAX_POS_64;
    lim3    = w3 ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
    neg3    = 64'd0 - mag3[63:0];
    res_c   = '0;
    if (op3 == OP_INT32 || op3 == OP_INT64) begin
      if (nan3 || big3 || mag3[64]) res_c = maxpos3;
      else if (!s3 ? mag3[63:0] >= lim3 : mag3[63:0] > lim3) res_c = maxpos3;
      else if (s3) res_c = w3 ? {32'd0, neg3[31:0]} : neg3;
      else res_c = mag3[63:0];
    end else if (nan3) begin
      if (mz3) res_c = sgl3 ? (sbit3 | 64'h7f80_0000) : (sbit3 | 64'h7ff0_0000_0000_0000);
      else res_c = sgl3 ? (sbit3 | MAX_POS_32) : (sbit3 | MAX_POS_64);
    end else if (e3 == 11'd0 || ex3 == 13'd0) begin
      res_c = sbit3;
    end else if (ex3 == maxexp3) begin
      if (to_inf3) res_c = sgl3 ? (sbit3 | 64'h7f80_0000) : (sbit3 | 64'h7ff0_0000_0000_0000);
      else res_c = sgl3 ? (sbit3 | 64'h7f7f_ffff) : (sbit3 | 64'h7fef_ffff_ffff_ffff);
    end else begin
      if (sgl3) res_c = sbit3 | {32'd0, 1'b0, ex3[7:0], frac3[22:0]};
      else res_c = sbit3 | {1'b0, ex3[10:0], frac3[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
    if (adv) begin
      result_word <= res_c;
    end
  end

  // A held result must not change while stalled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_word))
    else $error("result changed under stall");

  // Input stall reflects only a blocked output.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // An accepted transaction reaches the output while the pipeline keeps advancing.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
    else $error("transaction lost in pipeline");

endmodule

[dv/testbench.sv]
// Testbench for double_to_format_convert_rm: drives random and directed conversions
// through the valid/stall handshake and checks every result against a local predictor.
// Depends on dtfc_pkg and the converter RTL.
`timescale 1ns / 1ps
module testbench;
  import dtfc_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  rm;
    logic [63:0] val;
  } conv_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [2:0]  rounding_mode = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_word;

  conv_req_t   pending_q[$];
  logic [63:0] expected_words[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          drain_hold = 1'b0;
  int          long_hold = 0;
  int          gap_left = 0;
  int          burst_left = 0;

  always #1 clk = ~clk;

  double_to_format_convert_rm dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .rounding_mode(rounding_mode), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .result_word(result_word)
  );

  function automatic logic [63:0] int_convert(logic s, logic [10:0] e, logic [51:0] m,
                                              logic [2:0] rm, bit w);
    logic [63:0] maxpos, lim, mag, rem, half, sig, r;
    bit big, up;
    int sh;
    maxpos = w ? MAX_POS_32 : MAX_POS_64;
    lim = w ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
    rem = 0; half = 1; big = 0; up = 0; mag = 0;
    if (e == 11'd2047) return maxpos;
    if (e < 11'd1012) begin
      rem = ((e != 0) || (m != 0)) ? 64'd1 : 64'd0;
      half = 2;
    end else begin
      sig = {12'd1, m};
      if (e >= 11'd1087) big = 1;
      else if (e >= 11'd1075) mag = sig << (e - 11'd1075);
      else begin
        sh = 1075 - int'(e);
        mag = sig >> sh;
        rem = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
      end
    end
    if (!big && rem != 0) begin
      if (rm == RM_NEAREST) up = (rem > half) || (rem == half && mag[0]);
      else if (rm == RM_UP) up = !s;
      else if (rm == RM_DOWN) up = s;
      if (up) mag = mag + 1;
    end
    if (big) return maxpos;
    if (!s ? (mag >= lim) : (mag > lim)) return maxpos;
    r = s ? -mag : mag;
    if (w) r = r & 64'hffff_ffff;
    return r;
  endfunction

  function automatic logic [63:0] float_convert(logic s, logic [10:0] e, logic [51:0] m,
                                                logic [2:0] rm, bit sgl);
    int nfrac, drop;
    longint maxexp, bias, ex;
    logic [63:0] sbit, fmask, frac, rem, half;
    bit up, to_inf;
    nfrac = sgl ? 23 : 52;
    maxexp = sgl ? 255 : 2047;
    bias = sgl ? 127 : 1023;
    sbit = 64'(s) << (sgl ? 31 : 63);
    fmask = (64'd1 << nfrac) - 1;
    drop = 52 - nfrac;
    rem = 0; half = 1; up = 0;
    if (e == 11'd2047) begin
      if (m == 0) return sbit | (64'(maxexp) << nfrac);
      return sbit | (sgl ? MAX_POS_32 : MAX_POS_64);
    end
    if (e == 0) return sbit;
    frac = 64'(m) >> drop;
    if (drop != 0) begin
      rem = 64'(m) & ((64'd1 << drop) - 1);
      half = 64'd1 << (drop - 1);
    end
    ex = longint'(e) - 1023;
    if (rem != 0) begin
      if (rm == RM_NEAREST) up = (rem > half) || (rem == half && frac[0]);
      else if (rm == RM_UP) up = !s;
      else if (rm == RM_DOWN) up = s;
    end
    if (up) begin
      frac = frac + 1;
      if ((frac >> nfrac) != 0) begin
        frac = 0;
        ex = ex + 1;
      end
    end
    ex = ex + bias;
    if (ex < 0) ex = 0;
    if (ex > maxexp) ex = maxexp;
    if (ex == maxexp) begin
      to_inf = 1;
      if (rm == RM_ZERO) to_inf = 0;
      else if (rm == RM_UP) to_inf = !s;
      else if (rm == RM_DOWN) to_inf = s;
      if (!to_inf) begin
        ex = maxexp - 1;
        frac = fmask;
      end else frac = 0;
    end
    if (ex == 0) return sbit;
    return sbit | (64'(ex) << nfrac) | (frac & fmask);
  endfunction

  function automatic logic [63:0] predict_word(conv_req_t t);
    logic [2:0] rm;
    rm = (t.rm > RM_LEGACY) ? RM_LEGACY : t.rm;
    case (t.op)
      OP_SINGLE: return float_convert(t.val[63], t.val[62:52], t.val[51:0], rm, 1);
      OP_DOUBLE: return float_convert(t.val[63], t.val[62:52], t.val[51:0], rm, 0);
      OP_INT32:  return int_convert(t.val[63], t.val[62:52], t.val[51:0], rm, 1);
      default:   return int_convert(t.val[63], t.val[62:52], t.val[51:0], rm, 0);
    endcase
  endfunction

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    logic [10:0] e;
    int pick;
    v = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    // steer the exponent toward the interesting ranges
    case (pick)
      0: e = 11'd0;
      1: e = 11'd2047;
      2: e = 11'($urandom_range(1012, 1087));
      3: e = 11'($urandom_range(890, 1160));
      4: e = 11'($urandom_range(1, 12));
      5: e = 11'($urandom_range(2035, 2046));
      6: e = 11'($urandom_range(1020, 1070));
      default: e = 11'($urandom);
    endcase
    v[62:52] = e;
    if ($urandom_range(0, 7) == 0) v[51:0] = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 7) == 0) v[28:0] = {1'b1, 28'd0};
    return v;
  endfunction

  task automatic add_item(logic [1:0] op, logic [2:0] rm, logic [63:0] val);
    conv_req_t t;
    t.op = op; t.rm = rm; t.val = val;
    pending_q.push_back(t);
  endtask

  // driver: bursts with random gaps; record the expectation when a transaction is taken
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) expected_words.push_back(predict_word(pending_q.pop_front()));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (drain_hold || pending_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        opcode <= pending_q[0].op;
        rounding_mode <= pending_q[0].rm;
        value <= pending_q[0].val;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall <= 1'b1;
    end else if (cycles == 400) begin
      long_hold <= 200;
      out_stall <= 1'b1;
    end else if (cycles % 1000 < 300) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // monitor
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", result_word);
      end else begin
        want = expected_words.pop_front();
        if (want !== result_word) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result_word mismatch: expected %h actual %h", want, result_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("double_to_format_convert_rm test failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] specials[12];
    specials = '{64'h0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
                 64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0001, 64'h000f_ffff_ffff_ffff,
                 64'h7fef_ffff_ffff_ffff, 64'h41df_ffff_ffc0_0000, 64'hc1e0_0000_0010_0000,
                 64'h43e0_0000_0000_0000, 64'h3fe0_0000_0000_0000, 64'h3810_0000_1000_0000};
    for (int i = 0; i < 12; i++)
      add_item(2'(i), 3'(i % 8), specials[i]);
    for (int r = 0; r < 8; r++)
      for (int o = 0; o < 4; o++)
        if ((r * 4 + o) % 3 == 0) add_item(2'(o), 3'(r), 64'hbff8_0000_0000_0000);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 1040; i++) begin
      if (i == 500) begin
        // wait until the converter has fully drained, then pause the sender
        wait (pending_q.size() == 0 && expected_words.size() == 0);
        drain_hold = 1'b1;
        repeat (5) @(posedge clk);
        drain_hold = 1'b0;
      end
      add_item(2'($urandom), 3'($urandom), rand_double());
      if (i % 20 == 0) @(posedge clk);
    end
    wait (pending_q.size() == 0 && !in_valid);
    wait (expected_words.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("double_to_format_convert_rm test passed");
    else
      $display("double_to_format_convert_rm test failed");
    $finish;
  end
endmodule

[sim.f]
sv/dtfc_pkg.sv
sv/double_to_format_convert_rm.sv
dv/testbench.sv
